/* hw/rtl/lpa_pkg.sv */
// shared constants, types and the arctangent table for the launch angle solver
package lpa_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_W    = 32;
  localparam int ANGLE_W = 24;
  localparam int P_W     = 61;   // 100 * v^2 scaled down, below 2^61 for eight or more fraction bits
  localparam int X_W     = 41;   // 981 * distance
  localparam int RAD_W   = 124;  // discriminant, below 2^122
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 4;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int VEC_W   = 64;
  localparam int CORDIC_ITERS = 48;

  localparam logic [9:0]  G_SCALED        = 10'd981;
  localparam logic [19:0] G_SQ_SCALED     = 20'd962361;
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
  localparam logic [63:0] PI_QUARTER_Q62  = 64'h3243F6A8885A308D;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};

  typedef struct packed {
    logic             ok;
    logic [P_W-1:0]   p;
    logic [X_W-1:0]   x0;
  } lpa_side_t;

  typedef struct packed {
    logic               found;
    logic [ANGLE_W-1:0] angle;
  } lpa_result_t;

  // atan(2^-i) in radians, 62 fraction bits, series truncated term by term
  function automatic logic [63:0] atan_q62(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned e;
    sum = '0;
    if (i == 0) begin
      sum = PI_QUARTER_Q62;
    end else begin
      for (int unsigned k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          if (k[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
    end
    return sum;
  endfunction

endpackage

/* hw/rtl/lpa_front.sv */
// range checks, products and discriminant of the launch equation
module lpa_front #(
  parameter int FRAC_BITS = lpa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [lpa_pkg::IN_W-1:0] in_h,
  input  logic signed [lpa_pkg::IN_W-1:0] in_v,
  input  logic signed [lpa_pkg::IN_W-1:0] in_m,
  input  logic signed [lpa_pkg::IN_W-1:0] in_d,
  input  logic signed [lpa_pkg::IN_W-1:0] in_t,
  input  logic signed [lpa_pkg::IN_W-1:0] in_b,
  input  logic signed [lpa_pkg::IN_W-1:0] in_w,
  output logic                          out_valid,
  output lpa_pkg::lpa_side_t            out_side,
  output logic [lpa_pkg::RAD_W-1:0]     out_rad
);
  import lpa_pkg::*;

  // stage 1: checks, squares of speed and distance, height difference
  logic               vld1_r, ok1_r;
  logic [61:0]        v2_1_r, d2_1_r;
  logic signed [32:0] c1_r;
  logic [30:0]        d1_r;
  logic               ok1_nxt;

  // stage 2
  logic               vld2_r;
  lpa_side_t          side2_r;
  logic signed [43:0] gc2_r;
  logic [63:0]        csq2_r;
  logic [61:0]        d2_2_r;
  logic [68:0]        p100;
  logic signed [65:0] csq_full;

  // stage 3
  logic               vld3_r;
  lpa_side_t          side3_r;
  logic [61:0]        s3_r;
  logic [64:0]        sum3_r;
  logic signed [62:0] s_nxt;

  // stage 4
  logic               vld4_r;
  lpa_side_t          side4_r;
  logic [59:0]        hh4_r;
  logic [61:0]        hl4_r;
  logic [63:0]        ll4_r;
  logic [51:0]        glo4_r;
  logic [52:0]        ghi4_r;

  // stage 5
  logic               vld5_r;
  lpa_side_t          side5_r;
  logic [127:0]       lhs5_r, rhs5_r;

  // stage 6
  logic               vld6_r;
  lpa_side_t          side6_r;
  logic [RAD_W-1:0]   rad6_r;
  logic [128:0]       diff;

  assign ok1_nxt = !in_h[31] && !in_v[31] && (in_v != '0) && !in_m[31] && (in_m != '0) &&
                   !in_d[31] && (in_d != '0) && !in_b[31] && !in_w[31];

  assign p100     = (69'(v2_1_r) << 6) + (69'(v2_1_r) << 5) + (69'(v2_1_r) << 2);
  assign csq_full = 66'(c1_r) * 66'(c1_r);
  assign s_nxt    = $signed({2'b00, side2_r.p}) + 63'(gc2_r);
  assign diff     = {1'b0, lhs5_r} - {1'b0, rhs5_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1_r  <= ok1_nxt;
      v2_1_r <= 62'(in_v[30:0]) * 62'(in_v[30:0]);
      d2_1_r <= 62'(in_d[30:0]) * 62'(in_d[30:0]);
      c1_r   <= {in_h[31], in_h} - {in_t[31], in_t};
      d1_r   <= in_d[30:0];

      side2_r.ok <= ok1_r;
      side2_r.p  <= P_W'(p100 >> FRAC_BITS);
      side2_r.x0 <= X_W'(d1_r) * X_W'(G_SCALED);
      gc2_r      <= 44'(c1_r) * 44'(G_SCALED);
      csq2_r     <= csq_full[63:0];
      d2_2_r     <= d2_1_r;

      // an unreachable target shows as a negative s
      side3_r.p  <= side2_r.p;
      side3_r.x0 <= side2_r.x0;
      side3_r.ok <= side2_r.ok && !s_nxt[62];
      s3_r       <= s_nxt[61:0];
      sum3_r     <= 65'(csq2_r) + 65'(d2_2_r);

      side4_r <= side3_r;
      hh4_r   <= 60'(s3_r[61:32]) * 60'(s3_r[61:32]);
      hl4_r   <= 62'(s3_r[61:32]) * 62'(s3_r[31:0]);
      ll4_r   <= 64'(s3_r[31:0]) * 64'(s3_r[31:0]);
      glo4_r  <= 52'(sum3_r[31:0]) * 52'(G_SQ_SCALED);
      ghi4_r  <= 53'(sum3_r[64:32]) * 53'(G_SQ_SCALED);

      side5_r <= side4_r;
      lhs5_r  <= (128'(hh4_r) << 64) + (128'(hl4_r) << 33) + 128'(ll4_r);
      rhs5_r  <= (128'(ghi4_r) << 32) + 128'(glo4_r);

      side6_r.p  <= side5_r.p;
      side6_r.x0 <= side5_r.x0;
      side6_r.ok <= side5_r.ok && !diff[128];
      rad6_r     <= diff[RAD_W-1:0];
    end
  end

  assign out_valid = vld6_r;
  assign out_side  = side6_r;
  assign out_rad   = rad6_r;

endmodule

/* hw/rtl/lpa_sqrt.sv */
// pipelined integer square root, one result bit per stage
module lpa_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  lpa_pkg::lpa_side_t         in_side,
  input  logic [lpa_pkg::RAD_W-1:0]  in_rad,
  output logic                       out_valid,
  output lpa_pkg::lpa_side_t         out_side,
  output logic [lpa_pkg::ROOT_W-1:0] out_root
);
  import lpa_pkg::*;

  logic             vld_r  [SQRT_STEPS];
  lpa_side_t        side_r [SQRT_STEPS];
  logic [RAD_W-1:0] rad_r  [SQRT_STEPS];
  logic [REM_W-1:0] rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic              v_in;
    lpa_side_t         s_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in, r2, trial;
    logic [ROOT_W-1:0] root_in;
    logic              take;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign s_in    = in_side;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = vld_r[j-1];
      assign s_in    = side_r[j-1];
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign r2    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= s_in;
        rad_r[j]  <= rad_in << 2;
        rem_r[j]  <= take ? (r2 - trial) : r2;
        root_r[j] <= {root_in[ROOT_W-2:0], take};
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];

endmodule

/* hw/rtl/lpa_cordic.sv */
// operand normalisation, cordic vectoring and radian to degree conversion
module lpa_cordic #(
  parameter int FRAC_BITS = lpa_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  lpa_pkg::lpa_side_t         in_side,
  input  logic [lpa_pkg::ROOT_W-1:0] in_root,
  output logic                       out_valid,
  output lpa_pkg::lpa_result_t       out_result
);
  import lpa_pkg::*;

  localparam int RND_SH = 54 - FRAC_BITS;
  localparam logic [61:0] RND = 62'd1 << (RND_SH - 1);

  // operand stage
  logic        vlda_r, oka_r;
  logic [61:0] ya_r, xa_r, mxa_r;
  logic [61:0] y_sum, x_ext;

  // leading one, per byte
  logic        vldb_r, okb_r;
  logic [61:0] yb_r, xb_r;
  logic [7:0]  nzb_r;
  logic [2:0]  posb_r [8];
  logic [63:0] mx_pad;
  logic [7:0]  nz_nxt;
  logic [2:0]  pos_nxt [8];

  // shift amount
  logic        vldc_r, okc_r;
  logic [61:0] yc_r, xc_r;
  logic [5:0]  shc_r;
  logic [5:0]  lead;

  // normalised vectors
  logic        vldd_r, okd_r;
  logic signed [VEC_W-1:0] xd_r, yd_r;
  logic [63:0] xw, yw;

  // cordic
  logic                    vld_r [CORDIC_ITERS];
  logic                    ok_r  [CORDIC_ITERS];
  logic signed [VEC_W-1:0] x_r   [CORDIC_ITERS];
  logic signed [VEC_W-1:0] y_r   [CORDIC_ITERS];
  logic signed [VEC_W-1:0] z_r   [CORDIC_ITERS];

  // degrees
  logic        vlde_r, oke_r;
  logic [60:0] prode_r;
  logic [62:0] zc;
  logic        vldf_r;
  lpa_result_t resf_r;
  logic [61:0] deg_full;
  logic        sat;

  assign x_ext = 62'(in_side.x0);
  assign y_sum = 62'(in_side.p) + in_root;
  assign mx_pad = {2'b00, mxa_r};

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_nxt[g]  = |mx_pad[8*g +: 8];
      pos_nxt[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (mx_pad[8*g + k]) begin
          pos_nxt[g] = 3'(k);
        end
      end
    end
  end

  always_comb begin
    lead = '0;
    for (int g = 0; g < 8; g++) begin
      if (nzb_r[g]) begin
        lead = {3'(g), posb_r[g]};
      end
    end
  end

  // left shift with two guard bits puts the leading one on bit 63 (59 in xd_r)
  assign xw = {xc_r, 2'b00} << shc_r;
  assign yw = {yc_r, 2'b00} << shc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
      vldb_r <= 1'b0;
      vldc_r <= 1'b0;
      vldd_r <= 1'b0;
    end else if (en) begin
      vlda_r <= in_valid;
      vldb_r <= vlda_r;
      vldc_r <= vldb_r;
      vldd_r <= vldc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oka_r  <= in_side.ok;
      ya_r   <= y_sum;
      xa_r   <= x_ext;
      mxa_r  <= (y_sum > x_ext) ? y_sum : x_ext;

      okb_r  <= oka_r;
      yb_r   <= ya_r;
      xb_r   <= xa_r;
      nzb_r  <= nz_nxt;
      posb_r <= pos_nxt;

      okc_r  <= okb_r;
      yc_r   <= yb_r;
      xc_r   <= xb_r;
      shc_r  <= 6'd61 - lead;

      okd_r  <= okc_r;
      xd_r   <= $signed({4'b0000, xw[63:4]});
      yd_r   <= $signed({4'b0000, yw[63:4]});
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic [63:0] ATAN = atan_q62(i);
    logic                    v_in, ok_in;
    logic signed [VEC_W-1:0] x_in, y_in, z_in, dx, dy;

    if (i == 0) begin : g_first
      assign v_in  = vldd_r;
      assign ok_in = okd_r;
      assign x_in  = xd_r;
      assign y_in  = yd_r;
      assign z_in  = '0;
    end else begin : g_next
      assign v_in  = vld_r[i-1];
      assign ok_in = ok_r[i-1];
      assign x_in  = x_r[i-1];
      assign y_in  = y_r[i-1];
      assign z_in  = z_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok_r[i] <= ok_in;
        if (!y_in[VEC_W-1]) begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + $signed(ATAN);
        end else begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - $signed(ATAN);
        end
      end
    end
  end

  assign zc       = z_r[CORDIC_ITERS-1][VEC_W-1] ? '0 : z_r[CORDIC_ITERS-1][62:0];
  assign deg_full = (62'(prode_r) + RND) >> RND_SH;
  assign sat      = |deg_full[61:ANGLE_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlde_r <= 1'b0;
      vldf_r <= 1'b0;
    end else if (en) begin
      vlde_r <= vld_r[CORDIC_ITERS-1];
      vldf_r <= vlde_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oke_r   <= ok_r[CORDIC_ITERS-1];
      prode_r <= 61'(zc[62:32]) * 61'(DEG_PER_RAD_Q24);

      resf_r.found <= oke_r;
      if (!oke_r) begin
        resf_r.angle <= '0;
      end else if (sat) begin
        resf_r.angle <= ANGLE_MAX;
      end else begin
        resf_r.angle <= deg_full[ANGLE_W-1:0];
      end
    end
  end

  assign out_valid  = vldf_r;
  assign out_result = resf_r;

endmodule

/* hw/rtl/projectile_launch_angle_solver.sv */
// top level of the launch angle solver: pipeline and output buffer
// Takes one request per clock while in_ready is high and returns one result per request,
// in order. Each request passes through the range checks and the discriminant, the square
// root (one root bit per stage), normalisation, 48 cordic steps and the degree conversion.
// A two-entry output buffer keeps requests flowing while a result waits; the pipeline
// halts only once both entries are full. No reset sweep is needed.
module projectile_launch_angle_solver #(
  parameter int FRAC_BITS = lpa_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_launch_height,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_launch_speed,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_body_mass,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_target_distance,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_target_height,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_barrier_distance,
  input  logic signed [lpa_pkg::IN_W-1:0]   in_barrier_width,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_solution_found,
  output logic signed [lpa_pkg::ANGLE_W-1:0] out_launch_angle
);
  import lpa_pkg::*;

  logic              adv;
  logic              fr_valid, sq_valid, res_valid;
  lpa_side_t         fr_side, sq_side;
  logic [RAD_W-1:0]  fr_rad;
  logic [ROOT_W-1:0] sq_root;
  lpa_result_t       res;

  lpa_result_t slot_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        push, pop;

  assign adv      = (count_r != 2'd2);
  assign in_ready = adv;

  lpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_h      (in_launch_height),
    .in_v      (in_launch_speed),
    .in_m      (in_body_mass),
    .in_d      (in_target_distance),
    .in_t      (in_target_height),
    .in_b      (in_barrier_distance),
    .in_w      (in_barrier_width),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_rad   (fr_rad)
  );

  lpa_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_rad    (fr_rad),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  lpa_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (sq_valid),
    .in_side    (sq_side),
    .in_root    (sq_root),
    .out_valid  (res_valid),
    .out_result (res)
  );

  // output buffer
  assign push = res_valid && adv;
  assign pop  = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= res;
    end
  end

  assign out_valid          = (count_r != 2'd0);
  assign out_solution_found = slot_r[rptr_r].found;
  assign out_launch_angle   = $signed(slot_r[rptr_r].angle);

`ifndef NO_ASSERTIONS
  a_no_angle_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_solution_found |-> out_launch_angle == '0)
    else $error("failed request carries a non-zero angle");

  a_angle_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_solution_found |-> !out_launch_angle[ANGLE_W-1])
    else $error("negative launch angle reported");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !adv |=> res_valid && $stable(res))
    else $error("pipeline result lost during stall");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("output buffer count mismatch");
`endif

endmodule
